[sv/lrgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lrgs_pkg;

   // Table geometry.
   localparam int TOPICS        = 16;
   localparam int TOPIC_BITS    = 4;
   localparam int STAR_VALUES   = 5;
   localparam int COUNT_BITS    = 20;
   localparam int ITS_DEPTH     = 327680;
   localparam int ITS_ADDR_BITS = 19;
   localparam int IT_ADDR_BITS  = 16;

   // Arithmetic widths.
   localparam int CFG_BITS   = 24;
   localparam int SUMB_BITS  = 27;
   localparam int OPND_BITS  = 37;
   localparam int RATIO_BITS = 53;
   localparam int W_BITS     = 48;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [W_BITS-1:0]     W_SAT   = '1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   // Register indexes.
   localparam logic [2:0] CSR_ALPHA  = 3'd0;
   localparam logic [2:0] CSR_BETA1  = 3'd1;
   localparam logic [2:0] CSR_BETA2  = 3'd2;
   localparam logic [2:0] CSR_BETA3  = 3'd3;
   localparam logic [2:0] CSR_BETA4  = 3'd4;
   localparam logic [2:0] CSR_BETA5  = 3'd5;
   localparam logic [2:0] CSR_TOPICS = 3'd6;
   localparam logic [2:0] CSR_STARS  = 3'd7;

   // Controller to datapath commands.
   typedef struct packed {
      logic                     clr_wr;
      logic [ITS_ADDR_BITS-1:0] clr_addr;
      logic                     load;
      logic                     rd;
      logic [TOPIC_BITS-1:0]    topic;
      logic                     wr_inc;
      logic                     wr_dec;
      logic                     total_clr;
      logic                     w_start;
      logic                     thr_calc;
      logic                     out_load;
      logic [TOPIC_BITS-1:0]    out_topic;
      logic [1:0]               out_status;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic                  cmd_bit;
      logic [TOPIC_BITS-1:0] old_topic;
      logic [TOPIC_BITS-1:0] nk_m1;
      logic                  range_bad;
      logic                  any_zero;
      logic                  w_done;
      logic                  prefix_ge;
      logic                  rsp_free;
   } stat_type;

endpackage

`default_nettype wire

[sv/lrgs_weight.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrgs_weight (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire [lrgs_pkg::OPND_BITS-1:0]    num,
   input  wire [lrgs_pkg::OPND_BITS-1:0]    den,
   input  wire [lrgs_pkg::OPND_BITS-1:0]    mul,
   output logic                             done,
   output logic [lrgs_pkg::W_BITS-1:0]      w
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_MUL  = 2'd2;

   logic [1:0]                          ph_ff, ph_in;
   logic [5:0]                          cnt_ff, cnt_in;
   logic [lrgs_pkg::RATIO_BITS-1:0]     dvd_ff, dvd_in;
   logic [lrgs_pkg::RATIO_BITS-1:0]     quo_ff, quo_in;
   logic [lrgs_pkg::OPND_BITS-1:0]      rem_ff, rem_in;
   logic [lrgs_pkg::OPND_BITS-1:0]      den_ff, den_in;
   logic [lrgs_pkg::OPND_BITS-1:0]      mul_ff, mul_in;
   logic [63:0]                         acc_ff, acc_in;
   logic                                ovf_ff, ovf_in;
   logic                                done_ff, done_in;
   logic [lrgs_pkg::W_BITS-1:0]         w_ff, w_in;
   logic [lrgs_pkg::OPND_BITS:0]        rsh;
   logic [65:0]                         msum;
   logic                                movf;

   // One quotient bit per cycle, then one multiplier bit per cycle, MSB first.
   always_comb begin
      rsh  = {rem_ff, dvd_ff[lrgs_pkg::RATIO_BITS-1]};
      msum = {1'b0, acc_ff, 1'b0} + (mul_ff[lrgs_pkg::OPND_BITS-1] ?
             {13'd0, quo_ff} : 66'd0);
      movf = ovf_ff | (|msum[65:64]);
      ph_in   = ph_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      mul_in  = mul_ff;
      acc_in  = acc_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      w_in    = w_ff;
      case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               if (den == '0 || mul == '0) begin
                  w_in    = '0;
                  done_in = 1'b1;
               end else begin
                  dvd_in = {num, 16'd0};
                  quo_in = '0;
                  rem_in = '0;
                  den_in = den;
                  mul_in = mul;
                  cnt_in = 6'(lrgs_pkg::RATIO_BITS - 1);
                  ph_in  = PH_DIV;
               end
            end
         end
         PH_DIV: begin
            if (rsh >= {1'b0, den_ff}) begin
               rem_in = lrgs_pkg::OPND_BITS'(rsh - {1'b0, den_ff});
               quo_in = {quo_ff[lrgs_pkg::RATIO_BITS-2:0], 1'b1};
            end else begin
               rem_in = rsh[lrgs_pkg::OPND_BITS-1:0];
               quo_in = {quo_ff[lrgs_pkg::RATIO_BITS-2:0], 1'b0};
            end
            dvd_in = {dvd_ff[lrgs_pkg::RATIO_BITS-2:0], 1'b0};
            if (cnt_ff == 6'd0) begin
               cnt_in = 6'(lrgs_pkg::OPND_BITS - 1);
               acc_in = '0;
               ovf_in = 1'b0;
               ph_in  = PH_MUL;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         PH_MUL: begin
            acc_in = msum[63:0];
            ovf_in = movf;
            mul_in = {mul_ff[lrgs_pkg::OPND_BITS-2:0], 1'b0};
            if (cnt_ff == 6'd0) begin
               w_in    = movf ? lrgs_pkg::W_SAT : msum[63:16];
               done_in = 1'b1;
               ph_in   = PH_IDLE;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         default: ph_in = PH_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         done_ff <= done_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      mul_ff <= mul_in;
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      w_ff   <= w_in;
   end

   assign done = done_ff;
   assign w    = w_ff;

endmodule

`default_nettype wire

[sv/lrgs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrgs_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  lrgs_pkg::stat_type   stat,
   output lrgs_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_CHECK   = 4'd2;
   localparam logic [3:0] S_OLD     = 4'd3;
   localparam logic [3:0] S_W_RD    = 4'd4;
   localparam logic [3:0] S_W_START = 4'd5;
   localparam logic [3:0] S_W_WAIT  = 4'd6;
   localparam logic [3:0] S_THR     = 4'd7;
   localparam logic [3:0] S_SCAN    = 4'd8;
   localparam logic [3:0] S_BUMP_RD = 4'd9;
   localparam logic [3:0] S_BUMP_WR = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   logic [3:0]                              state_ff, state_in;
   logic [lrgs_pkg::ITS_ADDR_BITS-1:0]      clr_ff, clr_in;
   logic [lrgs_pkg::TOPIC_BITS-1:0]         k_ff, k_in;
   logic [lrgs_pkg::TOPIC_BITS-1:0]         res_topic_ff, res_topic_in;
   logic [1:0]                              res_status_ff, res_status_in;

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      k_in          = k_ff;
      res_topic_in  = res_topic_ff;
      res_status_in = res_status_ff;
      cmd           = '0;
      cmd.clr_addr  = clr_ff;
      cmd.topic     = k_ff;
      cmd.out_topic  = res_topic_ff;
      cmd.out_status = res_status_ff;
      req_tready    = (state_ff == S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (clr_ff == lrgs_pkg::ITS_ADDR_BITS'(lrgs_pkg::ITS_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_topic_in = stat.old_topic;
            if (stat.range_bad) begin
               res_status_in = lrgs_pkg::STATUS_RANGE;
               state_in      = S_DONE;
            end else begin
               cmd.rd    = 1'b1;
               cmd.topic = stat.old_topic;
               state_in  = S_OLD;
            end
         end
         S_OLD: begin
            if (!stat.cmd_bit) begin
               cmd.wr_inc    = 1'b1;
               res_status_in = lrgs_pkg::STATUS_OK;
               state_in      = S_DONE;
            end else if (stat.any_zero) begin
               res_status_in = lrgs_pkg::STATUS_UNDERFLOW;
               state_in      = S_DONE;
            end else begin
               cmd.wr_dec    = 1'b1;
               cmd.total_clr = 1'b1;
               k_in          = '0;
               state_in      = S_W_RD;
            end
         end
         S_W_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_W_START;
         end
         S_W_START: begin
            cmd.w_start = 1'b1;
            state_in    = S_W_WAIT;
         end
         S_W_WAIT: begin
            if (stat.w_done) begin
               if (k_ff == stat.nk_m1) begin
                  state_in = S_THR;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_W_RD;
               end
            end
         end
         S_THR: begin
            cmd.thr_calc = 1'b1;
            k_in         = '0;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            if (stat.prefix_ge || k_ff == stat.nk_m1) begin
               res_topic_in = k_ff;
               state_in     = S_BUMP_RD;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_BUMP_RD: begin
            cmd.rd    = 1'b1;
            cmd.topic = res_topic_ff;
            state_in  = S_BUMP_WR;
         end
         S_BUMP_WR: begin
            cmd.wr_inc    = 1'b1;
            res_status_in = lrgs_pkg::STATUS_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Loop index and pending result.
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      res_topic_ff  <= res_topic_in;
      res_status_ff <= res_status_in;
   end

endmodule

`default_nettype wire

[sv/lrgs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrgs_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [47:0]           req_tdata,
   input  wire [0:0]            req_tuser,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   input  wire                  csr_wen,
   input  wire [2:0]            csr_index,
   input  wire [23:0]           csr_wdata,
   input  lrgs_pkg::cmd_type    cmd,
   output lrgs_pkg::stat_type   stat
);

   localparam int CB = lrgs_pkg::COUNT_BITS;
   localparam int TB = lrgs_pkg::TOPIC_BITS;

   // Configuration registers.
   logic [23:0] alpha_ff;
   logic [23:0] beta_ff [0:4];
   logic [4:0]  topics_ff;
   logic [2:0]  stars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= 24'd65536;
         beta_ff[0] <= 24'd65536;
         beta_ff[1] <= 24'd65536;
         beta_ff[2] <= 24'd65536;
         beta_ff[3] <= 24'd65536;
         beta_ff[4] <= 24'd65536;
         topics_ff  <= 5'd16;
         stars_ff   <= 3'd5;
      end else if (csr_wen) begin
         case (csr_index)
            lrgs_pkg::CSR_ALPHA:  alpha_ff   <= csr_wdata;
            lrgs_pkg::CSR_BETA1:  beta_ff[0] <= csr_wdata;
            lrgs_pkg::CSR_BETA2:  beta_ff[1] <= csr_wdata;
            lrgs_pkg::CSR_BETA3:  beta_ff[2] <= csr_wdata;
            lrgs_pkg::CSR_BETA4:  beta_ff[3] <= csr_wdata;
            lrgs_pkg::CSR_BETA5:  beta_ff[4] <= csr_wdata;
            lrgs_pkg::CSR_TOPICS: topics_ff  <= csr_wdata[4:0];
            lrgs_pkg::CSR_STARS:  stars_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Effective topic and star counts, and the sum of the betas in use.
   logic [2:0]                        ns;
   logic [TB-1:0]                     nk_m1;
   logic [lrgs_pkg::SUMB_BITS-1:0]    sum_beta;

   always_comb begin
      if (stars_ff == 3'd0)      ns = 3'd1;
      else if (stars_ff > 3'd5)  ns = 3'd5;
      else                       ns = stars_ff;
      if (topics_ff == 5'd0)       nk_m1 = '0;
      else if (topics_ff > 5'd16)  nk_m1 = '1;
      else                         nk_m1 = TB'(topics_ff - 5'd1);
      sum_beta = '0;
      for (int i = 0; i < 5; i++) begin
         if (3'(i) < ns) sum_beta = sum_beta + lrgs_pkg::SUMB_BITS'(beta_ff[i]);
      end
   end

   // Item registers, taken on transfer.
   logic          cmd_bit_ff;
   logic [11:0]   user_ff, item_ff;
   logic [2:0]    star_ff;
   logic [TB-1:0] old_ff;
   logic [15:0]   u_ff;
   logic [23:0]   beta_v_ff;
   logic [lrgs_pkg::SUMB_BITS-1:0] sum_beta_ff;
   logic [2:0]    v;

   assign v = star_ff - 3'd1;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_bit_ff  <= req_tuser[0];
         user_ff     <= req_tdata[11:0];
         item_ff     <= req_tdata[23:12];
         star_ff     <= req_tdata[26:24];
         old_ff      <= req_tdata[30:27];
         u_ff        <= req_tdata[46:31];
         sum_beta_ff <= sum_beta;
         case (req_tdata[26:24])
            3'd2:    beta_v_ff <= beta_ff[1];
            3'd3:    beta_v_ff <= beta_ff[2];
            3'd4:    beta_v_ff <= beta_ff[3];
            3'd5:    beta_v_ff <= beta_ff[4];
            default: beta_v_ff <= beta_ff[0];
         endcase
      end
   end

   // Count table addresses for the commanded topic.
   logic [lrgs_pkg::ITS_ADDR_BITS-1:0] its_base, its_addr, its_waddr_ff;
   logic [lrgs_pkg::IT_ADDR_BITS-1:0]  it_addr, ut_addr, it_waddr_ff, ut_waddr_ff;

   assign its_base = lrgs_pkg::ITS_ADDR_BITS'({item_ff, cmd.topic});
   assign its_addr = (its_base << 2) + its_base + lrgs_pkg::ITS_ADDR_BITS'(v);
   assign it_addr  = {item_ff, cmd.topic};
   assign ut_addr  = {user_ff, cmd.topic};

   // Count tables with registered reads.
   logic [CB-1:0] its_mem [0:lrgs_pkg::ITS_DEPTH-1];
   logic [CB-1:0] it_mem  [0:(1 << lrgs_pkg::IT_ADDR_BITS)-1];
   logic [CB-1:0] ut_mem  [0:(1 << lrgs_pkg::IT_ADDR_BITS)-1];
   logic [CB-1:0] rd_its_ff, rd_it_ff, rd_ut_ff;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_its_ff    <= its_mem[its_addr];
         rd_it_ff     <= it_mem[it_addr];
         rd_ut_ff     <= ut_mem[ut_addr];
         its_waddr_ff <= its_addr;
         it_waddr_ff  <= it_addr;
         ut_waddr_ff  <= ut_addr;
      end
   end

   function automatic logic [CB-1:0] step_count(input logic [CB-1:0] x, input logic dec);
      if (dec)                        return x - 1'b1;
      else if (x == lrgs_pkg::CNT_MAX) return x;
      else                            return x + 1'b1;
   endfunction

   // Write port: clearing pass, or read-modify-write of the last read.
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         its_mem[cmd.clr_addr]                             <= '0;
         it_mem[cmd.clr_addr[lrgs_pkg::IT_ADDR_BITS-1:0]]  <= '0;
         ut_mem[cmd.clr_addr[lrgs_pkg::IT_ADDR_BITS-1:0]]  <= '0;
      end else if (cmd.wr_inc || cmd.wr_dec) begin
         its_mem[its_waddr_ff] <= step_count(rd_its_ff, cmd.wr_dec);
         it_mem[it_waddr_ff]   <= step_count(rd_it_ff, cmd.wr_dec);
         ut_mem[ut_waddr_ff]   <= step_count(rd_ut_ff, cmd.wr_dec);
      end
   end

   // Weight operands and the shared divide and multiply unit.
   logic [lrgs_pkg::OPND_BITS-1:0] num, den, mul;
   logic                           w_done;
   logic [lrgs_pkg::W_BITS-1:0]    w;

   assign num = {1'b0, rd_its_ff, 16'd0} + lrgs_pkg::OPND_BITS'(beta_v_ff);
   assign den = {1'b0, rd_it_ff, 16'd0} + lrgs_pkg::OPND_BITS'(sum_beta_ff);
   assign mul = {1'b0, rd_ut_ff, 16'd0} + lrgs_pkg::OPND_BITS'(alpha_ff);

   lrgs_weight u_weight (
      .clock (clock),
      .reset (reset),
      .start (cmd.w_start),
      .num   (num),
      .den   (den),
      .mul   (mul),
      .done  (w_done),
      .w     (w)
   );

   // Saturating prefix sums and the threshold.
   logic [lrgs_pkg::W_BITS-1:0] total_ff, thr_ff;
   logic [lrgs_pkg::W_BITS-1:0] prefix_ff [0:lrgs_pkg::TOPICS-1];
   logic [lrgs_pkg::W_BITS:0]   tsum;
   logic [63:0]                 thr_prod;

   assign tsum     = {1'b0, total_ff} + {1'b0, w};
   assign thr_prod = 64'(u_ff) * 64'(total_ff);

   always_ff @(posedge clock) begin
      if (cmd.total_clr) begin
         total_ff <= '0;
      end else if (w_done) begin
         total_ff <= tsum[lrgs_pkg::W_BITS] ? lrgs_pkg::W_SAT : tsum[lrgs_pkg::W_BITS-1:0];
         prefix_ff[cmd.topic] <= tsum[lrgs_pkg::W_BITS] ? lrgs_pkg::W_SAT :
                                 tsum[lrgs_pkg::W_BITS-1:0];
      end
      if (cmd.thr_calc) thr_ff <= thr_prod[63:16];
   end

   // Result register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_data_ff <= {2'b00, cmd.out_status, cmd.out_topic};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status back to the controller.
   always_comb begin
      stat.cmd_bit   = cmd_bit_ff;
      stat.old_topic = old_ff;
      stat.nk_m1     = nk_m1;
      stat.range_bad = (star_ff == 3'd0) || (star_ff > ns) || (old_ff > nk_m1);
      stat.any_zero  = (rd_its_ff == '0) || (rd_it_ff == '0) || (rd_ut_ff == '0);
      stat.w_done    = w_done;
      stat.prefix_ge = prefix_ff[cmd.topic] >= thr_ff;
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

endmodule

`default_nettype wire

[sv/lda_rating_gibbs_sampler_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Gibbs sampling step for a topic model of star ratings.
// The req channel carries one rating per transfer; req_tuser selects add (0) or
// resample (1). The rsp channel returns one result per rating: the topic after
// the step and a status (ok, count underflow, star or topic out of range).
// The csr port writes the priors and the topic and star counts in use; write it
// only while no rating is in flight.
// For a resample, each topic in use needs a read, a start step, a restoring divide,
// a shift-add multiply and a done step in the one weight unit; then a scan of the
// prefix sums picks the topic. The next rating is taken once the current one has
// reached the result register.
// After reset the count tables are zeroed one entry per cycle with req_tready low;
// csr writes are taken meanwhile.
// A stalled receiver holds the result register; one more rating can run to
// completion behind it and then waits until the register is free.
module lda_rating_gibbs_sampler_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [47:0]  req_tdata,   // user, item, star, old_topic, random_fraction
   input  wire [0:0]   req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // new_topic, status
   input  wire         csr_wen,
   input  wire [2:0]   csr_index,
   input  wire [23:0]  csr_wdata
);

   lrgs_pkg::cmd_type  cmd;
   lrgs_pkg::stat_type stat;

   // Sequencer.
   lrgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Count tables, weight arithmetic and result register.
   lrgs_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire
